@@ rtl/bse_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bse_pkg
// Shared types for the bitmap sort engine: the sequencer state encoding.
// ---------------------------------------------------------------------------
package bse_pkg;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_MUL,
    S_INS_WR,
    S_DRN_SCAN,
    S_DRN_OUT
  } bse_state_t;

endpackage
`default_nettype wire

@@ rtl/bse_bitmap_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bse_bitmap_ram
// Presence bitmap store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bse_bitmap_ram #(
  parameter int DEPTH  = 32768,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 15
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/bse_seq.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bse_seq
// Request sequencer: clearing pass, insert read-modify-write and drain scan
// over the bitmap words, with the scan cursor.
// ---------------------------------------------------------------------------
module bse_seq #(
  parameter int VALUE_BITS = 20,
  parameter int WORD_BITS  = 32,
  parameter int WORD_COUNT = 32768,
  parameter int WIDX_W     = 15,
  parameter int BIT_W      = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  req_type,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output logic      [VALUE_BITS-1:0] res_value,
  output logic                       res_empty,
  output logic                       wr_en,
  output logic      [WIDX_W-1:0]     wr_addr,
  output logic      [WORD_BITS-1:0]  wr_data,
  output logic                       rd_en,
  output logic      [WIDX_W-1:0]     rd_addr,
  input  wire logic [WORD_BITS-1:0]  rd_data
);
  import bse_pkg::*;

  localparam int SHIFT   = VALUE_BITS + BIT_W;
  localparam int RECIP_W = VALUE_BITS + 2;
  localparam int PROD_W  = VALUE_BITS + RECIP_W;
  localparam int FULL_W  = WIDX_W + BIT_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORD_COUNT - 1);

  bse_state_t          state, state_next;
  logic [WIDX_W-1:0]   clr_addr, clr_addr_next;
  logic [WIDX_W-1:0]   cursor, cursor_next;
  logic [WIDX_W-1:0]   chk_word, chk_word_next;
  logic [WIDX_W-1:0]   ins_word, ins_word_next;
  logic [BIT_W-1:0]    ins_bit, ins_bit_next;
  logic [VALUE_BITS-1:0] ins_val, ins_val_next;
  logic [PROD_W-1:0]   prod, prod_next;
  logic [VALUE_BITS-1:0] res_value_next;
  logic                res_empty_next;

  logic [WIDX_W-1:0]    quot;
  logic [BIT_W-1:0]     ins_rem;
  logic [WORD_BITS-1:0] low_iso;
  logic [BIT_W-1:0]     low_idx;
  logic [FULL_W-1:0]    found_val;

  // quotient by reciprocal, exact for the whole value range
  assign quot    = WIDX_W'(prod >> SHIFT);
  assign ins_rem = BIT_W'(FULL_W'(ins_val) - FULL_W'(quot) * FULL_W'(WORD_BITS));

  // lowest set bit of the word just read
  assign low_iso = rd_data & (~rd_data + WORD_BITS'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_iso[i]) begin
        low_idx = low_idx | BIT_W'(i);
      end
    end
  end

  assign found_val = FULL_W'(chk_word) * FULL_W'(WORD_BITS) + FULL_W'(low_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cursor   <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      cursor   <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    chk_word  <= chk_word_next;
    ins_word  <= ins_word_next;
    ins_bit   <= ins_bit_next;
    ins_val   <= ins_val_next;
    prod      <= prod_next;
    res_value <= res_value_next;
    res_empty <= res_empty_next;
  end

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    cursor_next    = cursor;
    chk_word_next  = chk_word;
    ins_word_next  = ins_word;
    ins_bit_next   = ins_bit;
    ins_val_next   = ins_val;
    prod_next      = prod;
    res_value_next = res_value;
    res_empty_next = res_empty;
    in_stall       = 1'b1;
    res_valid      = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = clr_addr;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = cursor;

    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == LAST_WORD) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + WIDX_W'(1);
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (req_type) begin
            rd_en         = 1'b1;
            rd_addr       = cursor;
            chk_word_next = cursor;
            state_next    = S_DRN_SCAN;
          end else begin
            ins_val_next = value;
            prod_next    = PROD_W'(value) * PROD_W'(RECIP);
            state_next   = S_INS_MUL;
          end
        end
      end
      S_INS_MUL: begin
        rd_en         = 1'b1;
        rd_addr       = quot;
        ins_word_next = quot;
        ins_bit_next  = ins_rem;
        state_next    = S_INS_WR;
      end
      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = ins_word;
        wr_data = rd_data | (WORD_BITS'(1) << ins_bit);
        if (ins_word < cursor) begin
          cursor_next = ins_word;
        end
        state_next = S_IDLE;
      end
      S_DRN_SCAN: begin
        if (rd_data != '0) begin
          wr_en          = 1'b1;
          wr_addr        = chk_word;
          wr_data        = rd_data & ~low_iso;
          cursor_next    = chk_word;
          res_value_next = found_val[VALUE_BITS-1:0];
          res_empty_next = 1'b0;
          state_next     = S_DRN_OUT;
        end else if (chk_word == LAST_WORD) begin
          cursor_next    = '0;
          res_value_next = '0;
          res_empty_next = 1'b1;
          state_next     = S_DRN_OUT;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = chk_word + WIDX_W'(1);
          chk_word_next = chk_word + WIDX_W'(1);
        end
      end
      S_DRN_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/bitmap_sort_engine_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_sort_engine_core
// Bitmap sort engine: insert values, drain them back in ascending order.
// ---------------------------------------------------------------------------
// One presence bit per value, packed WORD_BITS to a word in a single-port-read
// memory of ceil(2^VALUE_BITS / WORD_BITS) words. After reset a clearing pass
// writes every word, one per cycle, while input is stalled. An insert
// (req_type 0) uses a reciprocal multiply to find the word, then a read and
// a write back through the memory ports; it gives no result. A drain
// (req_type 1) reads the words from the scan cursor up to the first nonzero
// word (or to the last word when empty); one word is read per cycle. The
// drain returns the smallest value and clears its bit, or reports empty_res
// with value zero and rewinds the cursor. An output register holds each
// result so the next request can be taken while it waits.
// ---------------------------------------------------------------------------
module bitmap_sort_engine_core #(
  parameter int VALUE_BITS = 20,
  parameter int WORD_BITS  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  req_type,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [VALUE_BITS-1:0] sorted_value,
  output logic                       empty_res
);

  localparam int WORD_COUNT = ((1 << VALUE_BITS) + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);

  logic                  res_valid;
  logic                  res_ready;
  logic [VALUE_BITS-1:0] res_value;
  logic                  res_empty;
  logic                  wr_en;
  logic [WIDX_W-1:0]     wr_addr;
  logic [WORD_BITS-1:0]  wr_data;
  logic                  rd_en;
  logic [WIDX_W-1:0]     rd_addr;
  logic [WORD_BITS-1:0]  rd_data;

  bse_bitmap_ram #(
    .DEPTH  (WORD_COUNT),
    .WIDTH  (WORD_BITS),
    .ADDR_W (WIDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bse_seq #(
    .VALUE_BITS (VALUE_BITS),
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT),
    .WIDX_W     (WIDX_W),
    .BIT_W      (BIT_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_value (res_value),
    .res_empty (res_empty),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // output register
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      sorted_value <= res_value;
      empty_res    <= res_empty;
    end
  end

endmodule
`default_nettype wire
